// ----- sv/bpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types, codes and defaults for the bucketed priority packet queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int NUM_BUCKETS_DEF     = 10;
  localparam int BUCKET_DEPTH_DEF    = 256;
  localparam int PACKET_ID_LIMIT_DEF = 4096;

  localparam int OP_W   = 2;
  localparam int ID_W   = 12;
  localparam int AREA_W = 24;
  localparam int THR_W  = 16;
  localparam int ST_W   = 2;

  localparam logic [THR_W-1:0] THR_RESET = 16'd10;
  // bucket k boundary is threshold + (STEP_BASE << k)
  localparam int STEP_BASE = 10;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_LOW   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   packet_id;
    logic [AREA_W-1:0] area;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] out_packet_id;
    logic [ST_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic            load_in;
    logic            clr_step;
    logic            pick;
    logic            push_wr;
    logic            scan_init;
    logic            scan_rd;
    logic            sent_rd;
    logic            mark_sent;
    logic            scan_dec;
    logic            clear_all;
    logic            res_we;
    logic [ST_W-1:0] res_code;
    logic            res_take_id;
    logic            load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            drop_low;
    logic            full;
    logic            cnt_zero;
    logic            scan_last;
    logic            fresh;
    logic            clr_last;
  } stat_t;

endpackage

// ----- sv/bpq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_datapath
// Bucket rings, id store, sent map, threshold register and result registers.
// ----------------------------------------------------------------------------
module bpq_datapath import bpq_pkg::*; #(
  parameter int NUM_BUCKETS     = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH    = BUCKET_DEPTH_DEF,
  parameter int PACKET_ID_LIMIT = PACKET_ID_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data,
  input  in_word_t         in_word,
  input  cmd_t             cmd,
  output stat_t            st,
  output out_word_t        out_word
);

  localparam int BW         = $clog2(NUM_BUCKETS);
  localparam int SW         = $clog2(BUCKET_DEPTH);
  localparam int CW         = $clog2(BUCKET_DEPTH + 1);
  localparam int SD         = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int SAW        = $clog2(SD);
  localparam int SENT_DEPTH = (PACKET_ID_LIMIT < (1 << ID_W)) ? PACKET_ID_LIMIT : (1 << ID_W);
  localparam int SENT_AW    = $clog2(SENT_DEPTH);
  localparam int BND_W      = AREA_W + 1;

  localparam logic [BW-1:0]   TOP_BKT    = BW'(NUM_BUCKETS - 1);
  localparam logic [CW-1:0]   DEPTH_C    = CW'(BUCKET_DEPTH);
  localparam logic [SW:0]     DEPTH_S    = (SW + 1)'(BUCKET_DEPTH);
  localparam logic [SW-1:0]   LAST_SLOT  = SW'(BUCKET_DEPTH - 1);
  localparam logic [SAW-1:0]  DEPTH_A    = SAW'(BUCKET_DEPTH);
  localparam logic [31:0]     LIMIT_L    = 32'(PACKET_ID_LIMIT);
  localparam logic [SENT_AW-1:0] CLR_END = SENT_AW'(SENT_DEPTH - 1);

  logic [THR_W-1:0]   thr_r;
  in_word_t           in_r;
  logic [BW-1:0]      bkt_r;
  logic [SW-1:0]      head_r [NUM_BUCKETS];
  logic [CW-1:0]      cnt_r  [NUM_BUCKETS];
  logic [ID_W-1:0]    store_mem [SD];
  logic               sent_mem  [SENT_DEPTH];
  logic [ID_W-1:0]    store_q_r;
  logic [ID_W-1:0]    cand_r;
  logic               sent_q_r;
  logic [SENT_AW-1:0] clr_cnt_r;
  logic [ID_W-1:0]    res_id_r;
  logic [ST_W-1:0]    res_st_r;
  out_word_t          out_word_r;

  logic [BW-1:0]      pick_b;
  logic               found;
  logic [SW-1:0]      head_cur;
  logic [CW-1:0]      cnt_cur;
  logic [SW:0]        slot_sum;
  logic [SW:0]        slot_wrap;
  logic [SW-1:0]      head_adv;
  logic [SAW-1:0]     base_addr;
  logic [SAW-1:0]     wr_addr;
  logic [SAW-1:0]     rd_addr;
  logic               sent_we;
  logic [SENT_AW-1:0] sent_wa;
  logic               cand_ok;

  // first bucket whose boundary holds the area; the last one takes the rest
  always_comb begin
    pick_b = TOP_BKT;
    found  = 1'b0;
    for (int k = 0; k < NUM_BUCKETS - 1; k++) begin
      if (!found && ({1'b0, in_r.area} <=
          ({{(BND_W - THR_W){1'b0}}, thr_r} + (BND_W'(STEP_BASE) << k)))) begin
        pick_b = BW'(k);
        found  = 1'b1;
      end
    end
  end

  assign head_cur  = head_r[bkt_r];
  assign cnt_cur   = cnt_r[bkt_r];
  assign slot_sum  = {1'b0, head_cur} + (SW + 1)'(cnt_cur);
  assign slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
  assign head_adv  = (head_cur == LAST_SLOT) ? '0 : (head_cur + SW'(1));
  assign base_addr = SAW'(bkt_r) * DEPTH_A;
  assign wr_addr   = base_addr + SAW'(slot_wrap[SW-1:0]);
  assign rd_addr   = base_addr + SAW'(head_cur);

  assign cand_ok = (32'(cand_r) < LIMIT_L);

  assign st.op        = in_r.operation;
  assign st.drop_low  = (in_r.packet_id == '0) || (32'(in_r.packet_id) >= LIMIT_L) ||
                        (in_r.area < AREA_W'(thr_r));
  assign st.full      = (cnt_cur == DEPTH_C);
  assign st.cnt_zero  = (cnt_cur == '0);
  assign st.scan_last = (bkt_r == '0);
  assign st.fresh     = cand_ok && !sent_q_r;
  assign st.clr_last  = (clr_cnt_r == CLR_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RESET;
      clr_cnt_r <= '0;
      bkt_r     <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + SENT_AW'(1);
      end
      if (cmd.pick) begin
        bkt_r <= pick_b;
      end else if (cmd.scan_init) begin
        bkt_r <= TOP_BKT;
      end else if (cmd.scan_dec) begin
        bkt_r <= bkt_r - BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.clear_all) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.push_wr) begin
      cnt_r[bkt_r] <= cnt_cur + CW'(1);
    end else if (cmd.scan_rd) begin
      head_r[bkt_r] <= head_adv;
      cnt_r[bkt_r]  <= cnt_cur - CW'(1);
    end
  end

  // id store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      store_mem[wr_addr] <= in_r.packet_id;
    end
    if (cmd.scan_rd) begin
      store_q_r <= store_mem[rd_addr];
    end
  end

  // sent map: swept to zero after reset, then set by pops
  assign sent_we = cmd.clr_step || cmd.mark_sent;
  assign sent_wa = cmd.clr_step ? clr_cnt_r : cand_r[SENT_AW-1:0];

  always_ff @(posedge clk) begin
    if (sent_we) begin
      sent_mem[sent_wa] <= cmd.mark_sent;
    end
    if (cmd.sent_rd) begin
      sent_q_r <= sent_mem[store_q_r[SENT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_word;
    end
    if (cmd.sent_rd) begin
      cand_r <= store_q_r;
    end
    if (cmd.res_we) begin
      res_st_r <= cmd.res_code;
      res_id_r <= cmd.res_take_id ? cand_r : '0;
    end
    if (cmd.load_out) begin
      out_word_r.out_packet_id <= res_id_r;
      out_word_r.status        <= res_st_r;
    end
  end

  assign out_word = out_word_r;

endmodule

// ----- sv/bpq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_ctrl
// Sequencer: sent map sweep, push, pop scan, clear and output handshake.
// ----------------------------------------------------------------------------
module bpq_ctrl import bpq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_RDID = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (st.op)
          OP_PUSH: begin
            if (st.drop_low) begin
              cmd.res_we   = 1'b1;
              cmd.res_code = ST_LOW;
              state_nxt    = S_RESP;
            end else begin
              cmd.pick  = 1'b1;
              state_nxt = S_PUSH;
            end
          end
          OP_POP: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.res_we    = 1'b1;
            cmd.res_code  = ST_OK;
            state_nxt     = S_RESP;
          end
          OP_NONE: begin
            cmd.res_we   = 1'b1;
            cmd.res_code = ST_OK;
            state_nxt    = S_RESP;
          end
        endcase
      end
      S_PUSH: begin
        cmd.res_we = 1'b1;
        if (st.full) begin
          cmd.res_code = ST_FULL;
        end else begin
          cmd.push_wr  = 1'b1;
          cmd.res_code = ST_OK;
        end
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (!st.cnt_zero) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_RDID;
        end else if (st.scan_last) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_EMPTY;
          state_nxt    = S_RESP;
        end else begin
          cmd.scan_dec = 1'b1;
        end
      end
      S_RDID: begin
        cmd.sent_rd = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        priority if (st.fresh) begin
          cmd.mark_sent   = 1'b1;
          cmd.res_we      = 1'b1;
          cmd.res_code    = ST_OK;
          cmd.res_take_id = 1'b1;
          state_nxt       = S_RESP;
        end else if (st.scan_last) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_EMPTY;
          state_nxt    = S_RESP;
        end else begin
          cmd.scan_dec = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_RESP: begin
        // the previous word may still sit in the output register
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/bucketed_priority_packet_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_priority_packet_queue
// Priority queue of packet ids kept in FIFO buckets ranked by screen area.
// ----------------------------------------------------------------------------
// After reset the block sweeps the sent map to zero, one id per cycle, so
// in_ready stays low until all PACKET_ID_LIMIT ids (capped at 4096) are
// cleared; cfg writes are taken at any time. Every input word yields exactly
// one output word. One word is worked on at a time: a push goes through decode
// and bucket pick, ring write and response, a clear or a dropped push through
// decode and response; a pop through decode, a scan from the top bucket that
// passes each empty bucket and takes the head of the others (the head read from
// the id store and the sent map read are each a registered memory read), and
// response. The response cycle stretches while the previous word still waits
// in the output register, and the next word is accepted in the cycle after the
// output register is loaded. The output register lets the next word be
// accepted while the previous result waits for out_ready.
module bucketed_priority_packet_queue import bpq_pkg::*; #(
  parameter int NUM_BUCKETS     = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH    = BUCKET_DEPTH_DEF,
  parameter int PACKET_ID_LIMIT = PACKET_ID_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bpq_datapath #(
    .NUM_BUCKETS     (NUM_BUCKETS),
    .BUCKET_DEPTH    (BUCKET_DEPTH),
    .PACKET_ID_LIMIT (PACKET_ID_LIMIT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .cmd      (cmd),
    .st       (st),
    .out_word (out_word)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !st.full)
    else $error("push written into a full bucket");

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> !st.cnt_zero)
    else $error("head taken from an empty bucket");

  a_mark_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_sent |-> st.fresh)
    else $error("sent bit set for an id that was not fresh");

  a_no_id_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load_out) && out_word.status != ST_OK |-> out_word.out_packet_id == '0)
    else $error("nonzero id returned with a failing status");

endmodule

// ----- dv/tb_bucketed_priority_packet_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bucketed_priority_packet_queue
// Self-checking bench for the bucketed priority packet queue. A mirror of the
// buckets, ring pointers and sent map predicts the reply word of every
// accepted request word. Stimulus runs directed corner cases, a fill and
// ring-wrap sequence on the top bucket, then random phases under different
// area thresholds and handshake pressure.
// ----------------------------------------------------------------------------
import bpq_pkg::*;

class queue_mirror;
  logic [THR_W-1:0] threshold;
  logic [ID_W-1:0]  slots [NUM_BUCKETS_DEF][BUCKET_DEPTH_DEF];
  int               head [NUM_BUCKETS_DEF];
  int               fill [NUM_BUCKETS_DEF];
  bit               sent [PACKET_ID_LIMIT_DEF];
  out_word_t        expected_replies [$];
  int               mismatches;
  int               status_seen [4];

  function new();
    threshold  = THR_RESET;
    mismatches = 0;
    foreach (head[b]) begin
      head[b] = 0;
      fill[b] = 0;
    end
    foreach (sent[i]) sent[i] = 1'b0;
    foreach (status_seen[s]) status_seen[s] = 0;
  endfunction

  function out_word_t predict_reply(in_word_t w);
    out_word_t       r;
    int              b;
    int unsigned     bound;
    logic [ID_W-1:0] id;
    r.out_packet_id = '0;
    r.status        = ST_OK;
    case (w.operation)
      OP_PUSH: begin
        if (w.packet_id == '0 || w.area < threshold) begin
          r.status = ST_LOW;
        end else begin
          b = NUM_BUCKETS_DEF - 1;
          for (int k = NUM_BUCKETS_DEF - 2; k >= 0; k--) begin
            bound = int'(threshold) + (STEP_BASE << k);
            if (w.area <= bound) b = k;
          end
          if (fill[b] >= BUCKET_DEPTH_DEF) begin
            r.status = ST_FULL;
          end else begin
            slots[b][(head[b] + fill[b]) % BUCKET_DEPTH_DEF] = w.packet_id;
            fill[b]++;
          end
        end
      end
      OP_POP: begin
        r.status = ST_EMPTY;
        // one head per bucket, highest first, until a fresh id turns up
        for (int k = NUM_BUCKETS_DEF - 1; k >= 0; k--) begin
          if (fill[k] != 0 && r.status == ST_EMPTY) begin
            id      = slots[k][head[k]];
            head[k] = (head[k] + 1) % BUCKET_DEPTH_DEF;
            fill[k]--;
            if (!sent[id]) begin
              sent[id]        = 1'b1;
              r.out_packet_id = id;
              r.status        = ST_OK;
            end
          end
        end
      end
      OP_CLEAR: begin
        foreach (head[k]) begin
          head[k] = 0;
          fill[k] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function void note_request(in_word_t w);
    expected_replies.insert(expected_replies.size(), predict_reply(w));
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function void check_reply(out_word_t got);
    out_word_t want;
    if (expected_replies.size() == 0) begin
      report($sformatf("word with nothing expected, id %0d status %0d",
                       got.out_packet_id, got.status));
      return;
    end
    want = expected_replies[0];
    expected_replies.delete(0);
    status_seen[want.status]++;
    if (got.out_packet_id !== want.out_packet_id)
      report($sformatf("packet id expected %0d, got %0d",
                       want.out_packet_id, got.out_packet_id));
    if (got.status !== want.status)
      report($sformatf("status expected %0d, got %0d", want.status, got.status));
  endfunction
endclass

module tb_bucketed_priority_packet_queue;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          MAX_GAP     = 20;
  localparam int          MAX_STALL   = 16;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_ready;
  out_word_t        out_word;

  queue_mirror      board = new();
  logic [ID_W-1:0]  recent_ids [$];
  int               idle_pct;
  int               stall_pct;
  int unsigned      cycle_count = 0;

  bucketed_priority_packet_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d replies outstanding",
             cycle_count, board.expected_replies.size());
    $display("Verification failed");
    $finish;
  end

  // receiver side: random stalls with a bounded run length
  initial begin
    int stall_run;
    stall_run = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_run < MAX_STALL && $urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        stall_run++;
      end else begin
        out_ready <= 1'b1;
        stall_run = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_reply(out_word);
  end

  function automatic in_word_t make_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                         logic [AREA_W-1:0] area);
    in_word_t w;
    w.operation = op;
    w.packet_id = id;
    w.area      = area;
    return w;
  endfunction

  // called and left at a falling edge
  task automatic send_word(in_word_t w);
    int gaps;
    gaps = 0;
    while (gaps < MAX_GAP && $urandom_range(99) < idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    board.note_request(w);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    in_word_t    w;
    int          r;
    int unsigned t;
    repeat (count) begin
      t = 32'(board.threshold);
      r = $urandom_range(99);
      w.operation = (r < 55) ? OP_PUSH : (r < 92) ? OP_POP : (r < 96) ? OP_CLEAR : OP_NONE;
      w.packet_id = ID_W'($urandom_range(4095));
      w.area      = AREA_W'($urandom());
      if (w.operation == OP_PUSH) begin
        r = $urandom_range(99);
        if (r < 5)
          w.packet_id = '0;
        else if (r < 30 && recent_ids.size() > 0)
          w.packet_id = recent_ids[$urandom_range(recent_ids.size() - 1)];
        else
          w.packet_id = ID_W'($urandom_range(4095, 1));
        r = $urandom_range(99);
        if (r < 10 && t > 0)
          w.area = AREA_W'($urandom_range(t - 1));
        else if (r < 20)
          w.area = AREA_W'($urandom());
        else if (r < 35)
          w.area = AREA_W'(t + (STEP_BASE << $urandom_range(8)) + $urandom_range(1));
        else
          w.area = AREA_W'(t + $urandom_range(STEP_BASE << $urandom_range(9)));
        recent_ids.insert(recent_ids.size(), w.packet_id);
        if (recent_ids.size() > 48) recent_ids.delete(0);
      end
      send_word(w);
    end
  endtask

  initial begin
    int fails;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners at the reset threshold
    send_word(make_word(OP_POP, 12'hFFF, 24'hFFFFFF));
    send_word(make_word(OP_PUSH, 12'h000, 24'd500));
    send_word(make_word(OP_PUSH, 12'hFFF, 24'd9));
    send_word(make_word(OP_PUSH, 12'h001, 24'd10));
    for (int k = 0; k < NUM_BUCKETS_DEF - 1; k++)
      send_word(make_word(OP_PUSH, ID_W'(16 + k), AREA_W'(10 + (STEP_BASE << k))));
    send_word(make_word(OP_PUSH, 12'hAAA, 24'hFFFFFF));
    send_word(make_word(OP_NONE, 12'hFFF, 24'hFFFFFF));
    repeat (3) send_word(make_word(OP_POP, 12'h000, 24'h000000));
    // an already sent id on top must be skipped
    send_word(make_word(OP_PUSH, 12'hAAA, 24'h800000));
    send_word(make_word(OP_PUSH, 12'h555, 24'd21));
    send_word(make_word(OP_POP, 12'h000, 24'h000000));
    send_word(make_word(OP_CLEAR, 12'h555, 24'h555555));
    send_word(make_word(OP_PUSH, 12'hAAA, 24'd50));
    send_word(make_word(OP_POP, 12'h000, 24'h000000));

    // overfill the top bucket, drain half, refill so the ring wraps
    for (int i = 0; i < 260; i++)
      send_word(make_word(OP_PUSH, ID_W'(2048 + i), AREA_W'(24'hFFFFFF - i)));
    repeat (130) send_word(make_word(OP_POP, 12'h000, 24'h000000));
    for (int i = 0; i < 130; i++)
      send_word(make_word(OP_PUSH, ID_W'((i % 10 == 0) ? 2048 + i : 2400 + i),
                          AREA_W'(24'h00F000 + i)));
    wait_drained();

    write_threshold(16'd0);
    random_phase(130);
    wait_drained();

    write_threshold(16'hFFFF);
    idle_pct = 67;
    random_phase(130);
    wait_drained();

    write_threshold(THR_W'($urandom_range(65535)));
    idle_pct  = 0;
    stall_pct = 67;
    random_phase(130);
    wait_drained();

    write_threshold(THR_W'($urandom_range(2000)));
    idle_pct  = 14;
    stall_pct = 14;
    random_phase(130);
    wait_drained();

    repeat (64) @(posedge clk);
    fails = board.mismatches + board.expected_replies.size();
    $display("covered %0d replies: %0d ok, %0d dropped low, %0d dropped full, %0d empty pops",
             board.status_seen[ST_OK] + board.status_seen[ST_LOW] +
             board.status_seen[ST_FULL] + board.status_seen[ST_EMPTY],
             board.status_seen[ST_OK], board.status_seen[ST_LOW],
             board.status_seen[ST_FULL], board.status_seen[ST_EMPTY]);
    $display("thresholds reset, 0, max and random; gaps and stalls at 0, 14 and 67 percent");
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
